// ----- hdl/cmdline_key_value_extractor_defines.svh -----
// assertion macros used by the extractor parser
// needs clk_i and rst_ni in the module that expands them
`ifndef CMDLINE_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define CMDLINE_KEY_VALUE_EXTRACTOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define CKVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CKVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ckve_pkg.sv -----
// shared types and constants of the command line key/value extractor
// no dependencies
package ckve_pkg;

  localparam int KEY_BYTES  = 16;
  localparam int KIW        = $clog2(KEY_BYTES);
  localparam int KPX        = KIW + 1;
  localparam int KLEN_W     = 5;
  localparam int CFG_DATA_W = 64;

  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       found;
    logic       last;
  } ckve_res_t;

endpackage

// ----- hdl/ckve_in_reg.sv -----
// input register stage: holds one character beat until the parser takes it
// depends on nothing outside this file
module ckve_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  output logic       valid_o,
  output logic [7:0] char_o,
  input  logic       take_i
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;

endmodule

// ----- hdl/ckve_parser.sv -----
// token parser: phase machine, key compare and value streaming per character
// depends on ckve_pkg and the assertion macro header
`include "cmdline_key_value_extractor_defines.svh"

module ckve_parser
  import ckve_pkg::*;
#(
  parameter int MAX_KEY_CHARS   = 16,
  parameter int MAX_VALUE_CHARS = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        char_i,
  input  key_t              key_i,
  input  logic [KLEN_W-1:0] key_len_i,
  output logic              emit_o,
  output ckve_res_t         res_o
);

  localparam int KPW = $clog2(MAX_KEY_CHARS + 1);
  localparam int VCW = $clog2(MAX_VALUE_CHARS + 1);
  localparam logic [VCW-1:0] VMAX = VCW'(MAX_VALUE_CHARS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef enum logic [2:0] {
    PH_TOKEN_START,
    PH_DASH_CHECK,
    PH_NAME,
    PH_SKIP_TOKEN,
    PH_VALUE_START,
    PH_VALUE,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic           mis;
    logic [KPW-1:0] pos;
  } name_t;

  typedef struct packed {
    phase_e ph;
    name_t  nm;
  } step_t;

  function automatic name_t name_char(input logic [7:0] ch, input name_t st,
                                      input logic [KPW-1:0] eff, input key_t key);
    logic [KPX-1:0] pw;
    name_t r;
    pw = KPX'(st.pos);
    r  = st;
    if (!st.mis && (st.pos < eff) && (ch == key[pw[KIW-1:0]])) begin
      r.pos = st.pos + 1'b1;
    end else begin
      r.mis = 1'b1;
    end
    return r;
  endfunction

  function automatic step_t name_in(input logic [7:0] ch, input name_t st,
                                    input logic [KPW-1:0] eff, input key_t key);
    step_t r;
    r.ph = PH_NAME;
    r.nm = st;
    if (ch == CH_SPACE) begin
      r.ph = PH_TOKEN_START;
    end else if (ch == CH_EQUAL) begin
      r.ph = (!st.mis && (st.pos == eff)) ? PH_VALUE_START : PH_SKIP_TOKEN;
    end else begin
      r.nm = name_char(ch, st, eff, key);
    end
    return r;
  endfunction

  phase_e         phase_q, phase_d;
  name_t          name_q, name_d;
  logic           quoted_q, quoted_d;
  logic [VCW-1:0] cnt_q, cnt_d;

  logic [KPW-1:0] eff_len;
  name_t          fresh, dash_nm;
  step_t          st_name, st_fresh, st_dash;
  logic           vq, vterm;
  logic [VCW-1:0] vc, vc_inc;

  logic           mid_beat, data_beat, nul_fire, restart_ok;

  // key lengths above the limit act as the limit
  assign eff_len = (key_len_i > KLEN_W'(MAX_KEY_CHARS)) ? KPW'(MAX_KEY_CHARS)
                                                       : KPW'(key_len_i);

  assign fresh    = '0;
  assign st_name  = name_in(char_i, name_q, eff_len, key_i);
  assign st_fresh = name_in(char_i, fresh, eff_len, key_i);
  // a lone dash counts as a name character
  assign dash_nm  = name_char(CH_DASH, fresh, eff_len, key_i);
  assign st_dash  = name_in(char_i, dash_nm, eff_len, key_i);

  // first value character starts an unquoted value with a zero count, unless it is a quote
  assign vq     = (phase_q == PH_VALUE_START) ? 1'b0 : quoted_q;
  assign vc     = (phase_q == PH_VALUE_START) ? '0 : cnt_q;
  assign vc_inc = vc + 1'b1;
  assign vterm  = (vq && (char_i == CH_QUOTE)) || (!vq && (char_i == CH_SPACE));

  always_comb begin
    phase_d  = phase_q;
    name_d   = name_q;
    quoted_d = quoted_q;
    cnt_d    = cnt_q;
    emit_o   = 1'b0;
    res_o    = '0;
    if (char_i == CH_NUL) begin
      emit_o      = (phase_q != PH_DONE);
      res_o.found = (phase_q == PH_VALUE_START) || (phase_q == PH_VALUE);
      res_o.last  = 1'b1;
      phase_d     = PH_TOKEN_START;
      name_d      = '0;
      quoted_d    = 1'b0;
      cnt_d       = '0;
    end else begin
      unique case (phase_q)
        PH_TOKEN_START: begin
          if (char_i == CH_DASH) begin
            phase_d = PH_DASH_CHECK;
            name_d  = '0;
          end else if (char_i != CH_SPACE) begin
            phase_d = st_fresh.ph;
            name_d  = st_fresh.nm;
          end
        end
        PH_DASH_CHECK: begin
          if (char_i == CH_DASH) begin
            phase_d = PH_NAME;
            name_d  = '0;
          end else begin
            phase_d = st_dash.ph;
            name_d  = st_dash.nm;
          end
        end
        PH_NAME: begin
          phase_d = st_name.ph;
          name_d  = st_name.nm;
        end
        PH_SKIP_TOKEN: begin
          if (char_i == CH_SPACE) begin
            phase_d = PH_TOKEN_START;
          end
        end
        PH_VALUE_START, PH_VALUE: begin
          phase_d = PH_VALUE;
          cnt_d   = vc;
          if ((phase_q == PH_VALUE_START) && (char_i == CH_QUOTE)) begin
            quoted_d = 1'b1;
          end else begin
            quoted_d = vq;
            emit_o   = 1'b1;
            res_o.found = 1'b1;
            if (vterm) begin
              res_o.last = 1'b1;
              phase_d    = PH_DONE;
            end else begin
              cnt_d            = vc_inc;
              res_o.value_byte = char_i;
              res_o.byte_valid = 1'b1;
              if (vc_inc >= VMAX) begin
                res_o.last = 1'b1;
                phase_d    = PH_DONE;
              end
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_TOKEN_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOKEN_START;
      name_q   <= '0;
      quoted_q <= 1'b0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      name_q   <= name_d;
      quoted_q <= quoted_d;
      cnt_q    <= cnt_d;
    end
  end

  assign mid_beat   = emit_o && !res_o.last;
  assign data_beat  = res_o.byte_valid && res_o.found;
  assign nul_fire   = fire_i && (char_i == CH_NUL);
  assign restart_ok = (phase_q == PH_TOKEN_START) && (cnt_q == '0);

  `CKVE_ASSERT(a_partial_is_data, mid_beat |-> data_beat, "value beat without data")
  `CKVE_ASSERT_NEXT(a_line_end_resets, nul_fire, restart_ok, "line end did not restart search")
  `CKVE_ASSERT(a_key_pos_range, (name_q.pos <= KPW'(MAX_KEY_CHARS)), "key position past limit")
  `CKVE_ASSERT(a_value_count_range, (phase_q == PH_VALUE) |-> (cnt_q < VMAX), "value count at limit")

endmodule

// ----- hdl/ckve_out_reg.sv -----
// result register: holds one result beat until the sink takes it
// depends on ckve_pkg
module ckve_out_reg
  import ckve_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  logic      emit_i,
  input  ckve_res_t res_i,
  output logic      can_take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ckve_res_t res_o
);

  logic      valid_q, valid_d;
  ckve_res_t res_q;

  assign can_take_o = !valid_q || out_ready_i;
  // fire only happens when the held beat leaves or the register is empty
  assign valid_d    = fire_i ? emit_i : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/cmdline_key_value_extractor.sv -----
// top level of the command line key/value extractor: config registers and wiring
// depends on ckve_pkg, ckve_in_reg, ckve_parser and ckve_out_reg
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid_i/in_ready_o| char_byte_i
//   out     | out_valid_o/out_ready_i | value_byte_o byte_valid_o found_o last_o
//   config  | psel/penable/pwrite  | paddr pwdata prdata (64 bit, regs at 8*i)
//
// one character per cycle sustained while the output is not stalled; a beat is held
// in the input register and its result is registered in the output register.
// the phase machine in the parser closes a loop through its state registers.
// reset clears the search state and the key registers; no clearing pass.
// a stalled output holds its beat and freezes the parser; in_ready_o drops at
// once when the input register is full, else after one more character.
module cmdline_key_value_extractor
  import ckve_pkg::*;
#(
  parameter int MAX_KEY_CHARS   = 16,
  parameter int MAX_VALUE_CHARS = 255
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            value_byte_o,
  output logic                  byte_valid_o,
  output logic                  found_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
  logic [KLEN_W-1:0]     key_len_q;
  logic                  wr_en;
  logic [1:0]            reg_idx;
  key_t                  key;

  logic       a_valid, a_fire, can_take, emit;
  logic [7:0] a_char;
  ckve_res_t  res_c, res_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LOW:  key_low_q  <= pwdata;
        REG_KEY_HIGH: key_high_q <= pwdata;
        REG_KEY_LEN:  key_len_q  <= pwdata[KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_q;
      REG_KEY_HIGH: prdata = key_high_q;
      REG_KEY_LEN:  prdata = CFG_DATA_W'(key_len_q);
      default:      prdata = '0;
    endcase
  end

  assign key    = {key_high_q, key_low_q};
  assign a_fire = a_valid && can_take;

  ckve_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .valid_o     (a_valid),
    .char_o      (a_char),
    .take_i      (a_fire)
  );

  ckve_parser #(
    .MAX_KEY_CHARS   (MAX_KEY_CHARS),
    .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (a_fire),
    .char_i    (a_char),
    .key_i     (key),
    .key_len_i (key_len_q),
    .emit_o    (emit),
    .res_o     (res_c)
  );

  ckve_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (a_fire),
    .emit_i      (emit),
    .res_i       (res_c),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign value_byte_o = res_q.value_byte;
  assign byte_valid_o = res_q.byte_valid;
  assign found_o      = res_q.found;
  assign last_o       = res_q.last;

endmodule
